// File: sv/acmm_pkg.sv
// shared types and constants of the channel matrix mixer
package acmm_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int GAIN_W      = 16;
	localparam int CHAN_FLD_W  = 3;
	localparam int CFG_W       = 4;
	localparam int FRAC_BITS   = 15;
	localparam int SAMPLE_MAX  = 8388607;
	localparam int SAMPLE_MIN  = -8388608;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_GAIN   = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		CFG_IN_CHANNELS  = 1'b0,
		CFG_OUT_CHANNELS = 1'b1
	} cfg_idx_t;

	// control that travels alongside one product through the mac pipeline
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

// File: sv/acmm_in_if.sv
// input channel: samples and gain writes
interface acmm_in_if;
	logic                                 valid;
	logic                                 ready;
	acmm_pkg::op_t                        opcode;
	logic signed [acmm_pkg::SAMPLE_W-1:0] sample;
	logic [acmm_pkg::GAIN_W-1:0]          gain_value;
	logic [acmm_pkg::CHAN_FLD_W-1:0]      dest_channel;
	logic [acmm_pkg::CHAN_FLD_W-1:0]      src_channel;

	modport source (output valid, opcode, sample, gain_value, dest_channel, src_channel,
		input ready);
	modport sink (input valid, opcode, sample, gain_value, dest_channel, src_channel,
		output ready);
endinterface

// File: sv/acmm_out_if.sv
// output channel: mixed samples
interface acmm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [acmm_pkg::SAMPLE_W-1:0] mixed_sample;
	logic [acmm_pkg::CHAN_FLD_W-1:0]      out_channel;
	logic                                 frame_last;

	modport source (output valid, mixed_sample, out_channel, frame_last, input ready);
	modport sink (input valid, mixed_sample, out_channel, frame_last, output ready);
endinterface

// File: sv/acmm_mac.sv
// multiply-accumulate pipeline with floor shift and 24-bit saturation
module acmm_mac #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  acmm_pkg::mac_ctl_t                   ctl_s1,
	input  logic signed [acmm_pkg::SAMPLE_W-1:0] sample_s1,
	input  logic [acmm_pkg::GAIN_W-1:0]          gain_s1,
	output logic                                 done_s3,
	output logic signed [acmm_pkg::SAMPLE_W-1:0] result_q
);
	import acmm_pkg::*;

	localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
	localparam int ACC_W  = PROD_W + $clog2(MAX_CHANNELS) + 1;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);

	logic signed [PROD_W-1:0]   prod_s2;
	mac_ctl_t                   ctl_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    acc_base;
	logic signed [ACC_W-1:0]    acc_next;
	logic signed [ACC_W-1:0]    shifted;
	logic signed [SAMPLE_W-1:0] sat_res;

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(sample_s1) * PROD_W'($signed({1'b0, gain_s1}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			done_s3 <= 1'b0;
		end else begin
			ctl_s2  <= ctl_s1;
			done_s3 <= ctl_s2.vld && ctl_s2.last;
		end
	end

	always_comb begin
		acc_base = ctl_s2.first ? '0 : acc_q;
		acc_next = acc_base + ACC_W'(prod_s2);
		// arithmetic shift rounds toward minus infinity
		shifted  = acc_next >>> FRAC_BITS;
		priority if (shifted > SAT_HI) begin
			sat_res = SAMPLE_W'(SAMPLE_MAX);
		end else if (shifted < SAT_LO) begin
			sat_res = SAMPLE_W'(SAMPLE_MIN);
		end else begin
			sat_res = shifted[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_q <= acc_next;
		end
		if (ctl_s2.vld && ctl_s2.last) begin
			result_q <= sat_res;
		end
	end

endmodule

// File: sv/audio_channel_matrix_mixer_core.sv
// channel matrix mixer: top level with gain and frame memories and the frame sequencer
//
// sample_in carries interleaved 24-bit samples (opcode sample) and gain writes
// (opcode gain). Samples fill one frame of in_channels entries; gain writes store
// one Q1.15 gain, clamped to 1.0, and produce nothing.
// mix_out gives out_channels results per frame, the last one flagged frame_last.
// A sample that does not close a frame, and a gain write, leave the sequencer idle.
// After the closing sample, each output channel walks its nin products through
// one shared multiplier fed by the two memories: the issue state feeds the products
// in, the drain state empties the multiply-accumulate pipeline and the emit state
// loads the output register. Input is taken again only once the frame is emitted.
// The single multiply-accumulate unit and the one read port of each memory make
// the products go through one at a time.
// A finished result sits in the output register; a stalled receiver holds the
// sequencer before the next result but never drops or repeats one.
// Reset clears the gain table (per-entry valid bits), the frame position and sets
// both channel counts to 2; no clearing pass is needed. Channel count registers are
// written through cfg_we/cfg_index/cfg_data by the user only while idle, not enforced.
module audio_channel_matrix_mixer_core #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  acmm_pkg::cfg_idx_t               cfg_index,
	input  logic [acmm_pkg::CFG_W-1:0]       cfg_data,
	acmm_in_if.sink                          sample_in,
	acmm_out_if.source                       mix_out
);
	import acmm_pkg::*;

	localparam int IDX_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W      = $clog2(MAX_CHANNELS + 1);
	localparam int GAIN_DEPTH = MAX_CHANNELS * MAX_CHANNELS;
	localparam int GADDR_W    = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > MAX_CHANNELS) begin
			r = CNT_W'(MAX_CHANNELS);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	state_t               state_q;
	logic [CFG_W-1:0]     in_ch_q;
	logic [CFG_W-1:0]     out_ch_q;
	logic [IDX_W-1:0]     pos_q;
	logic [IDX_W-1:0]     k_q;
	logic [IDX_W-1:0]     j_q;
	logic [CNT_W-1:0]     nin;
	logic [CNT_W-1:0]     nout;

	logic [GAIN_W-1:0]          gain_mem [GAIN_DEPTH];
	logic [GAIN_DEPTH-1:0]      gv_q;
	logic signed [SAMPLE_W-1:0] fbuf_mem [MAX_CHANNELS];

	logic                       in_acc;
	logic                       is_gain;
	logic                       smp_wr;
	logic                       frame_done;
	logic                       k_last;
	logic                       j_last;
	logic                       gw_en;
	logic [GADDR_W-1:0]         gw_addr;
	logic [GAIN_W-1:0]          gw_val;
	logic [GADDR_W-1:0]         rd_addr;

	logic [GAIN_W-1:0]          gain_s1;
	logic                       gv_s1;
	logic signed [SAMPLE_W-1:0] fbuf_s1;
	logic [GAIN_W-1:0]          gain_eff;
	mac_ctl_t                   ctl_s1;
	logic                       mac_done;
	logic signed [SAMPLE_W-1:0] mac_result;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] mixed_q;
	logic [CHAN_FLD_W-1:0]      och_q;
	logic                       last_q;

	assign nin  = eff_count(in_ch_q);
	assign nout = eff_count(out_ch_q);

	assign sample_in.ready = (state_q == ST_IDLE);
	assign in_acc     = sample_in.valid && sample_in.ready;
	assign is_gain    = (sample_in.opcode == OP_GAIN);
	assign smp_wr     = in_acc && !is_gain;
	assign frame_done = (CNT_W'(pos_q) + CNT_W'(1)) >= nin;
	assign k_last     = (CNT_W'(k_q) + CNT_W'(1)) >= nin;
	assign j_last     = (CNT_W'(j_q) + CNT_W'(1)) >= nout;

	// entries outside the table are dropped
	assign gw_en   = in_acc && is_gain && (int'(sample_in.dest_channel) < MAX_CHANNELS)
		&& (int'(sample_in.src_channel) < MAX_CHANNELS);
	assign gw_addr = GADDR_W'(int'(sample_in.dest_channel) * MAX_CHANNELS
		+ int'(sample_in.src_channel));
	assign gw_val  = (sample_in.gain_value > GAIN_ONE) ? GAIN_ONE : sample_in.gain_value;
	assign rd_addr = GADDR_W'(int'(j_q) * MAX_CHANNELS + int'(k_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q  <= CFG_W'(2);
			out_ch_q <= CFG_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IN_CHANNELS:  in_ch_q  <= cfg_data;
				CFG_OUT_CHANNELS: out_ch_q <= cfg_data;
			endcase
		end
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (gw_en) begin
			gain_mem[gw_addr] <= gw_val;
		end
		if (smp_wr) begin
			fbuf_mem[pos_q] <= sample_in.sample;
		end
		gain_s1 <= gain_mem[rd_addr];
		gv_s1   <= gv_q[rd_addr];
		fbuf_s1 <= fbuf_mem[k_q];
	end

	// gain entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_q <= '0;
		end else if (gw_en) begin
			gv_q[gw_addr] <= 1'b1;
		end
	end

	assign gain_eff = gv_s1 ? gain_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld   <= (state_q == ST_ISSUE);
			ctl_s1.first <= (k_q == '0);
			ctl_s1.last  <= k_last;
		end
	end

	acmm_mac #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.sample_s1 (fbuf_s1),
		.gain_s1   (gain_eff),
		.done_s3   (mac_done),
		.result_q  (mac_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			k_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
			mixed_q     <= '0;
			och_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			// in the emit state the output register is always reloaded when it frees up
			if (mix_out.ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (smp_wr) begin
						if (frame_done) begin
							pos_q   <= '0;
							k_q     <= '0;
							j_q     <= '0;
							state_q <= ST_ISSUE;
						end else begin
							pos_q <= pos_q + IDX_W'(1);
						end
					end
				end
				ST_ISSUE: begin
					if (k_last) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// wait for the output register to free up
					if (!out_valid_q || mix_out.ready) begin
						out_valid_q <= 1'b1;
						mixed_q     <= mac_result;
						och_q       <= CHAN_FLD_W'(j_q);
						last_q      <= j_last;
						k_q         <= '0;
						if (j_last) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + IDX_W'(1);
							state_q <= ST_ISSUE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign mix_out.valid        = out_valid_q;
	assign mix_out.mixed_sample = mixed_q;
	assign mix_out.out_channel  = och_q;
	assign mix_out.frame_last   = last_q;

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(mix_out.valid && mix_out.frame_last) |-> (mix_out.out_channel == CHAN_FLD_W'(nout - CNT_W'(1))))
		else $error("frame_last on a beat that is not the final output channel");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_wr && frame_done) |=> (state_q == ST_ISSUE && k_q == '0 && j_q == '0))
		else $error("closing sample did not start the mix sequence");

	a_mac_done: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_DRAIN))
		else $error("mac result arrived outside the drain state");

endmodule

// File: sim/acmm_mix_checker.sv
// checker for the channel matrix mixer: predicts every frame's mix and compares result beats
module acmm_mix_checker #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  acmm_pkg::cfg_idx_t           cfg_index,
	input  logic [acmm_pkg::CFG_W-1:0]   cfg_data,
	acmm_in_if                           in_mon,
	acmm_out_if                          out_mon,
	output int                           mismatches,
	output int                           outstanding,
	output int                           results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import acmm_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mixed_sample;
		logic [CHAN_FLD_W-1:0]      out_channel;
		logic                       frame_last;
	} mix_beat_t;

	logic [GAIN_W-1:0]          gain_tbl [MAX_CHANNELS][MAX_CHANNELS];
	logic signed [SAMPLE_W-1:0] frame_buf [MAX_CHANNELS];
	int unsigned                frame_pos;
	logic [CFG_W-1:0]           in_count;
	logic [CFG_W-1:0]           out_count;
	mix_beat_t                  pending_mixes [$];
	int                         err_cnt;
	int                         seen_cnt;

	// 0 behaves as one channel, anything past the table as the full table
	function automatic int unsigned clip_count(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_CHANNELS)
			return MAX_CHANNELS;
		return v;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] mix_row(int unsigned row, int unsigned nin);
		longint acc;
		longint shifted;
		acc = 0;
		for (int k = 0; k < nin; k++)
			acc += longint'(frame_buf[k]) * longint'(gain_tbl[row][k]);
		// arithmetic shift floors toward minus infinity
		shifted = acc >>> FRAC_BITS;
		if (shifted > SAMPLE_MAX)
			shifted = SAMPLE_MAX;
		else if (shifted < SAMPLE_MIN)
			shifted = SAMPLE_MIN;
		return shifted[SAMPLE_W-1:0];
	endfunction

	task automatic store_gain(logic [GAIN_W-1:0] g, logic [CHAN_FLD_W-1:0] d,
		logic [CHAN_FLD_W-1:0] s);
		if (d < MAX_CHANNELS && s < MAX_CHANNELS)
			gain_tbl[d][s] = (g > GAIN_ONE) ? GAIN_ONE : g;
	endtask

	task automatic gather_sample(logic signed [SAMPLE_W-1:0] smp);
		int unsigned nin;
		int unsigned nout;
		mix_beat_t   b;
		nin  = clip_count(in_count);
		nout = clip_count(out_count);
		if (frame_pos < MAX_CHANNELS)
			frame_buf[frame_pos] = smp;
		// a position already past a lowered count closes the frame at once
		if (frame_pos + 1 < nin) begin
			frame_pos++;
		end else begin
			frame_pos = 0;
			for (int j = 0; j < nout; j++) begin
				b.mixed_sample = mix_row(j, nin);
				b.out_channel  = CHAN_FLD_W'(j);
				b.frame_last   = (j + 1 == nout);
				pending_mixes.push_back(b);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mix_beat_t got;
		mix_beat_t want;
		if (!arst_n) begin
			in_count  = 4'd2;
			out_count = 4'd2;
			frame_pos = 0;
			foreach (gain_tbl[d, s])
				gain_tbl[d][s] = '0;
			foreach (frame_buf[k])
				frame_buf[k] = '0;
			pending_mixes.delete();
			err_cnt  = 0;
			seen_cnt = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				got.mixed_sample = out_mon.mixed_sample;
				got.out_channel  = out_mon.out_channel;
				got.frame_last   = out_mon.frame_last;
				seen_cnt++;
				if (pending_mixes.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result beat: channel %0d sample %0d last %0b",
						$time, got.out_channel, got.mixed_sample, got.frame_last);
				end else begin
					want = pending_mixes.pop_front();
					if (got.mixed_sample !== want.mixed_sample) begin
						err_cnt++;
						$display("%0t: mixed_sample on channel %0d: expected %0d, got %0d",
							$time, want.out_channel, want.mixed_sample, got.mixed_sample);
					end
					if (got.out_channel !== want.out_channel) begin
						err_cnt++;
						$display("%0t: out_channel: expected %0d, got %0d",
							$time, want.out_channel, got.out_channel);
					end
					if (got.frame_last !== want.frame_last) begin
						err_cnt++;
						$display("%0t: frame_last on channel %0d: expected %0b, got %0b",
							$time, want.out_channel, want.frame_last, got.frame_last);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_IN_CHANNELS:  in_count = cfg_data;
					CFG_OUT_CHANNELS: out_count = cfg_data;
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				if (in_mon.opcode == OP_GAIN)
					store_gain(in_mon.gain_value, in_mon.dest_channel, in_mon.src_channel);
				else
					gather_sample(in_mon.sample);
			end
		end
		mismatches      <= err_cnt;
		outstanding     <= pending_mixes.size();
		results_checked <= seen_cnt;
	end

endmodule

// File: sim/tb_audio_channel_matrix_mixer_core.sv
// testbench top for the channel matrix mixer: stimulus, flow control and verdict
module tb_audio_channel_matrix_mixer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import acmm_pkg::*;

	localparam int STALL_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 32;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_BEATS   = 23;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;

	acmm_in_if  sample_in ();
	acmm_out_if mix_out ();

	int mismatches;
	int outstanding;
	int results_checked;
	int beats_sent     = 0;
	int gain_writes    = 0;
	int settings_used  = 0;
	int idle_cycles    = 0;
	int burst_left     = 0;
	bit long_hold_req  = 1'b0;

	always #2 clk = ~clk;

	audio_channel_matrix_mixer_core #(
		.MAX_CHANNELS(8)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_in (sample_in),
		.mix_out   (mix_out)
	);

	acmm_mix_checker #(
		.MAX_CHANNELS(8)
	) chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_mon          (sample_in),
		.out_mon         (mix_out),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return SAMPLE_W'(SAMPLE_MAX);
			1:       return SAMPLE_W'(SAMPLE_MIN);
			2, 3:    return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return GAIN_ONE;
			1:       return '0;
			2:       return GAIN_W'($urandom_range(32769, 65535));
			default: return GAIN_W'($urandom_range(0, 32768));
		endcase
	endfunction

	// sender: bursts of random length, a random gap between bursts
	task automatic offer_beat(op_t op, logic signed [SAMPLE_W-1:0] smp, logic [GAIN_W-1:0] g,
		logic [CHAN_FLD_W-1:0] d, logic [CHAN_FLD_W-1:0] s);
		if (burst_left == 0) begin
			sample_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		sample_in.valid        <= 1'b1;
		sample_in.opcode       <= op;
		sample_in.sample       <= smp;
		sample_in.gain_value   <= g;
		sample_in.dest_channel <= d;
		sample_in.src_channel  <= s;
		do @(posedge clk); while (!sample_in.ready);
		burst_left--;
		beats_sent++;
		if (op == OP_GAIN)
			gain_writes++;
	endtask

	// hold the sender until every predicted result has left, then let the core go quiet
	task automatic settle();
		sample_in.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = $urandom_range(1, 20);
	endtask

	task automatic set_channels(logic [CFG_W-1:0] nin, logic [CFG_W-1:0] nout);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IN_CHANNELS;
		cfg_data  <= nin;
		@(posedge clk);
		cfg_index <= CFG_OUT_CHANNELS;
		cfg_data  <= nout;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// unused fields of each beat carry noise
	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 25)
				offer_beat(OP_GAIN, pick_sample(), pick_gain(),
					CHAN_FLD_W'($urandom()), CHAN_FLD_W'($urandom()));
			else
				offer_beat(OP_SAMPLE, pick_sample(), GAIN_W'($urandom()),
					CHAN_FLD_W'($urandom()), CHAN_FLD_W'($urandom()));
		end
	endtask

	initial begin
		cfg_we                 <= 1'b0;
		cfg_index              <= CFG_IN_CHANNELS;
		cfg_data               <= '0;
		sample_in.valid        <= 1'b0;
		sample_in.opcode       <= OP_SAMPLE;
		sample_in.sample       <= '0;
		sample_in.gain_value   <= '0;
		sample_in.dest_channel <= '0;
		sample_in.src_channel  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gain table is clear after reset, so the first frame mixes to silence
		offer_beat(OP_SAMPLE, SAMPLE_W'(SAMPLE_MAX), '0, '0, '0);
		offer_beat(OP_SAMPLE, SAMPLE_W'(SAMPLE_MIN), '0, '0, '0);
		offer_beat(OP_GAIN, '0, 16'hFFFF, 3'd0, 3'd0);
		offer_beat(OP_GAIN, '0, GAIN_ONE, 3'd0, 3'd1);
		offer_beat(OP_GAIN, '0, 16'h8001, 3'd1, 3'd0);
		offer_beat(OP_GAIN, '0, 16'h0001, 3'd1, 3'd1);
		offer_beat(OP_GAIN, '0, 16'hFFFF, 3'd7, 3'd7);
		offer_beat(OP_GAIN, '0, 16'h4000, 3'd7, 3'd0);
		// full-scale frames saturate both ways
		offer_beat(OP_SAMPLE, SAMPLE_W'(SAMPLE_MAX), '0, '0, '0);
		offer_beat(OP_SAMPLE, SAMPLE_W'(SAMPLE_MAX), '0, '0, '0);
		offer_beat(OP_SAMPLE, SAMPLE_W'(SAMPLE_MIN), '0, '0, '0);
		offer_beat(OP_SAMPLE, SAMPLE_W'(SAMPLE_MIN), '0, '0, '0);
		// one-LSB samples: -1 at unity gain mixes to -1, +1 with -1 mixes to 0
		offer_beat(OP_SAMPLE, -24'sd1, '0, '0, '0);
		offer_beat(OP_SAMPLE, 24'sd0, '0, '0, '0);
		offer_beat(OP_SAMPLE, 24'sd1, '0, '0, '0);
		offer_beat(OP_SAMPLE, -24'sd1, '0, '0, '0);
		settle();
		// zero inputs acts as one, fifteen outputs as eight
		set_channels(4'd0, 4'd15);
		offer_beat(OP_SAMPLE, SAMPLE_W'(SAMPLE_MAX), '0, '0, '0);
		offer_beat(OP_SAMPLE, SAMPLE_W'(SAMPLE_MIN), '0, '0, '0);
		settle();
		// leave a frame part-filled, then shrink the input count under it
		set_channels(4'd8, 4'd1);
		offer_beat(OP_SAMPLE, SAMPLE_W'(SAMPLE_MAX), '0, '0, '0);
		offer_beat(OP_SAMPLE, -24'sd1, '0, '0, '0);
		offer_beat(OP_SAMPLE, 24'sd12345, '0, '0, '0);
		settle();
		set_channels(4'd2, 4'd2);
		offer_beat(OP_SAMPLE, SAMPLE_W'(SAMPLE_MIN), '0, '0, '0);

		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
				0:       set_channels(4'd9, 4'd8);
				1:       set_channels(4'd1, 4'd1);
				2:       set_channels(4'd15, 4'd0);
				3:       set_channels(4'd8, 4'd8);
				default: set_channels(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)));
			endcase
			// wide frames fill the output side fast while the receiver is held off
			if (p == 0)
				long_hold_req <= 1'b1;
			random_phase(PHASE_BEATS);
		end
		settle();

		$display("tb: %0d input beats sent, %0d of them gain writes, over %0d channel settings",
			beats_sent, gain_writes, settings_used);
		$display("tb: %0d mixed results compared against the predicted matrix", results_checked);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// receiver: ready follows a randomly chosen pattern, picked anew after each random span
	initial begin
		int  mode;
		int  span;
		int  hold;
		int  tick;
		bit  held;
		mix_out.ready <= 1'b0;
		held = 1'b0;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 80);
			repeat (span) begin
				@(posedge clk);
				tick++;
				if (long_hold_req && !held) begin
					held = 1'b1;
					hold = 0;
					mix_out.ready <= 1'b0;
					while (hold < LONG_HOLD) begin
						@(posedge clk);
						hold++;
					end
				end
				case (mode)
					0:       mix_out.ready <= 1'b1;
					1:       mix_out.ready <= ($urandom_range(0, 99) < 70);
					2:       mix_out.ready <= (tick % 3 != 0);
					default: mix_out.ready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	// watchdog on cycles in which no beat moves on either channel
	always @(posedge clk) begin
		if (!arst_n || (sample_in.valid && sample_in.ready) || (mix_out.valid && mix_out.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: no beat moved for %0d cycles at %0t", idle_cycles, $time);
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
